@@ src/utf8sop_pkg.sv @@
`timescale 1ns / 1ps

package utf8sop_pkg;

    localparam logic [15:0] SYL_BASE   = 16'hAC00;
    localparam logic [7:0]  LEAD_MASK  = 8'hF0;
    localparam logic [7:0]  LEAD_VAL   = 8'hE0;
    localparam logic [7:0]  ASCII_LIM  = 8'h80;
    localparam logic [15:0] CAP_RESET  = 16'd4096;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SECOND
    } t_phase;

    typedef struct packed {
        logic        has_code;
        logic        is_done;
        logic [7:0]  code;
        logic [15:0] count;
    } t_entry;

endpackage

@@ src/utf8sop_front.sv @@
`timescale 1ns / 1ps

module utf8sop_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_fifo_ready,
    output logic                  o_push,
    output utf8sop_pkg::t_entry   o_push_data
);

    utf8sop_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_lead, n_lead;
    logic [7:0]  r_second, n_second;
    logic [15:0] r_emitted, n_emitted;
    logic        r_full, n_full;
    logic [15:0] r_capacity;

    logic        w_accept;
    logic        w_cap_hit;
    logic        w_emit_second;
    logic [15:0] w_cnt_inc;
    logic [15:0] w_cp;

    // residue mod 5 via hex digit sum, since 16 is 1 mod 5
    function automatic logic [2:0] syl_op(input logic [15:0] cp);
        logic [15:0] d;
        logic [5:0]  s1;
        logic [4:0]  s2;
        logic [4:0]  r;
        d  = cp - utf8sop_pkg::SYL_BASE;
        s1 = 6'(d[3:0]) + 6'(d[7:4]) + 6'(d[11:8]) + 6'(d[15:12]);
        s2 = 5'(s1[5:4]) + 5'(s1[3:0]);
        if (s2 >= 5'd15) begin
            r = s2 - 5'd15;
        end else if (s2 >= 5'd10) begin
            r = s2 - 5'd10;
        end else if (s2 >= 5'd5) begin
            r = s2 - 5'd5;
        end else begin
            r = s2;
        end
        if (cp < utf8sop_pkg::SYL_BASE) begin
            r = 5'd0;
        end
        return r[2:0];
    endfunction

    assign o_in_ready  = i_fifo_ready;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && i_fifo_ready;
    assign w_cap_hit   = r_full || (r_emitted >= r_capacity);
    assign w_cnt_inc   = r_emitted + 16'd1;
    assign w_cp        = {r_lead, r_second[5:0], i_in_byte[5:0]};
    assign w_emit_second = (r_phase == utf8sop_pkg::PH_SECOND)
                        && (r_second < utf8sop_pkg::ASCII_LIM) && !w_cap_hit;

    always_comb begin
        n_phase   = r_phase;
        n_lead    = r_lead;
        n_second  = r_second;
        n_emitted = r_emitted;
        n_full    = r_full;
        o_push    = 1'b0;
        o_push_data.has_code = 1'b0;
        o_push_data.is_done  = 1'b0;
        o_push_data.code     = 8'd0;
        o_push_data.count    = r_emitted;
        if (w_accept) begin
            if (i_in_byte == 8'd0) begin
                o_push = 1'b1;
                o_push_data.has_code = w_emit_second;
                o_push_data.is_done  = 1'b1;
                o_push_data.code     = r_second;
                o_push_data.count    = w_emit_second ? w_cnt_inc : r_emitted;
                n_phase   = utf8sop_pkg::PH_IDLE;
                n_lead    = 4'd0;
                n_second  = 8'd0;
                n_emitted = 16'd0;
                n_full    = 1'b0;
            end else if (w_cap_hit) begin
                n_full = 1'b1;
            end else begin
                case (r_phase)
                    utf8sop_pkg::PH_LEAD: begin
                        n_second = i_in_byte;
                        n_phase  = utf8sop_pkg::PH_SECOND;
                    end
                    utf8sop_pkg::PH_SECOND: begin
                        o_push = 1'b1;
                        o_push_data.has_code = 1'b1;
                        o_push_data.code     = {5'd0, syl_op(w_cp)};
                        o_push_data.count    = w_cnt_inc;
                        n_emitted = w_cnt_inc;
                        n_phase   = utf8sop_pkg::PH_IDLE;
                        n_lead    = 4'd0;
                        n_second  = 8'd0;
                    end
                    utf8sop_pkg::PH_IDLE: begin
                        if ((i_in_byte & utf8sop_pkg::LEAD_MASK) == utf8sop_pkg::LEAD_VAL) begin
                            n_lead  = i_in_byte[3:0];
                            n_phase = utf8sop_pkg::PH_LEAD;
                        end else if (i_in_byte < utf8sop_pkg::ASCII_LIM) begin
                            o_push = 1'b1;
                            o_push_data.has_code = 1'b1;
                            o_push_data.code     = i_in_byte;
                            o_push_data.count    = w_cnt_inc;
                            n_emitted = w_cnt_inc;
                        end
                    end
                    default: begin
                        n_phase = utf8sop_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= utf8sop_pkg::PH_IDLE;
            r_lead     <= 4'd0;
            r_second   <= 8'd0;
            r_emitted  <= 16'd0;
            r_full     <= 1'b0;
            r_capacity <= utf8sop_pkg::CAP_RESET;
        end else begin
            r_phase   <= n_phase;
            r_lead    <= n_lead;
            r_second  <= n_second;
            r_emitted <= n_emitted;
            r_full    <= n_full;
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

endmodule

@@ src/utf8sop_fifo.sv @@
`timescale 1ns / 1ps

module utf8sop_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  utf8sop_pkg::t_entry               i_push_data,
    output logic                              o_ready,
    input  logic                              i_pop,
    output logic                              o_nonempty,
    output utf8sop_pkg::t_entry               o_pop_data,
    output logic [utf8sop_pkg::FIFO_AW:0]     o_count
);

    utf8sop_pkg::t_entry r_mem [utf8sop_pkg::FIFO_DEPTH];
    logic [utf8sop_pkg::FIFO_AW-1:0] r_wr, r_rd;
    logic [utf8sop_pkg::FIFO_AW:0]   r_cnt, n_cnt;

    assign o_ready    = (r_cnt != (utf8sop_pkg::FIFO_AW+1)'(utf8sop_pkg::FIFO_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_pop_data = r_mem[r_rd];
    assign o_count    = r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

@@ src/utf8sop_back.sv @@
`timescale 1ns / 1ps

module utf8sop_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_nonempty,
    input  utf8sop_pkg::t_entry   i_pop_data,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_code,
    output logic                  o_is_done,
    output logic [15:0]           o_code_count
);

    logic        r_valid, n_valid;
    logic        r_pend, n_pend;
    logic [7:0]  r_code, n_code;
    logic        r_done, n_done;
    logic [15:0] r_count, n_count;
    logic        w_free;

    assign w_free       = !r_valid || i_out_ready;
    assign o_out_valid  = r_valid;
    assign o_out_code   = r_code;
    assign o_is_done    = r_done;
    assign o_code_count = r_count;

    always_comb begin
        n_valid = r_valid && !i_out_ready;
        n_pend  = r_pend;
        n_code  = r_code;
        n_done  = r_done;
        n_count = r_count;
        o_pop   = 1'b0;
        if (w_free) begin
            if (r_pend) begin
                // done transaction following a code from the same entry
                n_valid = 1'b1;
                n_pend  = 1'b0;
                n_code  = 8'd0;
                n_done  = 1'b1;
            end else if (i_nonempty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                n_count = i_pop_data.count;
                if (i_pop_data.has_code) begin
                    n_code = i_pop_data.code;
                    n_done = 1'b0;
                    n_pend = i_pop_data.is_done;
                end else begin
                    n_code = 8'd0;
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_done  <= n_done;
        r_count <= n_count;
    end

endmodule

@@ src/utf8_syllable_opcode_parser.sv @@
`timescale 1ns / 1ps
// utf8 syllable opcode parser
// input channel: one byte per transaction on i_in_byte; a zero byte ends the string
// output channel: o_out_code, o_is_done, o_code_count per transaction; the last
//   transaction of a string has o_is_done set and carries the final count
// config channel: i_cfg_data writes the output capacity; o_cfg_ready is always high,
//   write only while no string transaction is in flight
// throughput: one byte per cycle while o_in_ready is high; a terminator that flushes a held
//   ascii byte gives two output transactions
// data path: classification is combinational, the entry enters the four-entry queue
//   at the accepting edge and moves into the output register once that register is free
// stalls: when i_out_ready is low the output register holds, the queue fills, and
//   o_in_ready drops once the queue is full
// reset: synchronous active-low; clears string state, the queue and the output,
//   and sets the capacity to 4096

module utf8_syllable_opcode_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_code,
    output logic        o_is_done,
    output logic [15:0] o_code_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic                          w_push;
    utf8sop_pkg::t_entry           w_push_data;
    logic                          w_fifo_ready;
    logic                          w_pop;
    logic                          w_nonempty;
    utf8sop_pkg::t_entry           w_pop_data;
    logic [utf8sop_pkg::FIFO_AW:0] w_count;

    utf8sop_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_fifo_ready (w_fifo_ready),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    utf8sop_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_ready     (w_fifo_ready),
        .i_pop       (w_pop),
        .o_nonempty  (w_nonempty),
        .o_pop_data  (w_pop_data),
        .o_count     (w_count)
    );

    utf8sop_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nonempty   (w_nonempty),
        .i_pop_data   (w_pop_data),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_code   (o_out_code),
        .o_is_done    (o_is_done),
        .o_code_count (o_code_count)
    );

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= (utf8sop_pkg::FIFO_AW+1)'(utf8sop_pkg::FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_done_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_done |-> o_out_code == 8'd0)
        else $error("done transaction with nonzero code");

    a_code_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_done |-> o_code_count != 16'd0)
        else $error("code transaction with zero count");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_nonempty)
        else $error("pop from empty queue");

endmodule

@@ bench/utf8_syllable_opcode_parser_tb.sv @@
`timescale 1ns / 1ps

module utf8_syllable_opcode_parser_tb;

    localparam logic [15:0] SYLLABLE_BASE    = 16'hAC00;
    localparam logic [7:0]  HI_NIBBLE        = 8'hF0;
    localparam logic [7:0]  THREE_BYTE_LEAD  = 8'hE0;
    localparam logic [7:0]  ASCII_END        = 8'h80;
    localparam logic [7:0]  NUL_BYTE         = 8'h00;
    localparam logic [15:0] CAPACITY_DEFAULT = 16'd4096;
    localparam int          OPCODE_SPAN      = 5;
    localparam int          SETTLE_CYCLES    = 8;
    localparam int          LIMIT_CYCLES     = 400000;
    localparam int          PHASE_BYTES      = 85;

    typedef struct {
        logic [7:0]  code;
        logic        done;
        logic [15:0] count;
    } t_code_item;

    class opcode_scoreboard;
        utf8sop_pkg::t_phase seq_phase;
        logic [3:0]  lead_nib;
        logic [7:0]  second_byte;
        logic [15:0] n_emitted;
        bit          is_full;
        logic [15:0] capacity;
        t_code_item  expected_codes[$];
        int          n_errors;

        function new();
            capacity = CAPACITY_DEFAULT;
            n_errors = 0;
            clear_string();
        endfunction

        function void clear_string();
            seq_phase   = utf8sop_pkg::PH_IDLE;
            lead_nib    = 4'd0;
            second_byte = 8'd0;
            n_emitted   = 16'd0;
            is_full     = 1'b0;
        endfunction

        function void set_capacity(logic [15:0] value);
            capacity = value;
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction

        function bit capacity_hit();
            if (is_full || n_emitted >= capacity) begin
                is_full = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic [7:0] opcode_of(logic [15:0] cp);
            if (cp < SYLLABLE_BASE)
                return 8'd0;
            return 8'((cp - SYLLABLE_BASE) % OPCODE_SPAN);
        endfunction

        function void add_code(logic [7:0] code, logic done);
            t_code_item item;
            item.code  = code;
            item.done  = done;
            item.count = n_emitted;
            expected_codes.push_back(item);
        endfunction

        function void note_byte(logic [7:0] b);
            logic [15:0] cp;
            if (b == NUL_BYTE) begin
                if (seq_phase == utf8sop_pkg::PH_SECOND && second_byte < ASCII_END
                        && !capacity_hit()) begin
                    n_emitted++;
                    add_code(second_byte, 1'b0);
                end
                add_code(8'd0, 1'b1);
                clear_string();
            end else if (!capacity_hit()) begin
                case (seq_phase)
                    utf8sop_pkg::PH_LEAD: begin
                        second_byte = b;
                        seq_phase   = utf8sop_pkg::PH_SECOND;
                    end
                    utf8sop_pkg::PH_SECOND: begin
                        cp = {lead_nib, second_byte[5:0], b[5:0]};
                        n_emitted++;
                        add_code(opcode_of(cp), 1'b0);
                        seq_phase   = utf8sop_pkg::PH_IDLE;
                        lead_nib    = 4'd0;
                        second_byte = 8'd0;
                    end
                    default: begin
                        if ((b & HI_NIBBLE) == THREE_BYTE_LEAD) begin
                            lead_nib  = b[3:0];
                            seq_phase = utf8sop_pkg::PH_LEAD;
                        end else if (b < ASCII_END) begin
                            n_emitted++;
                            add_code(b, 1'b0);
                        end
                    end
                endcase
            end
        endfunction

        function void check_result(logic [7:0] code, logic done, logic [15:0] count);
            t_code_item item;
            if (expected_codes.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected transaction, expected none, %s %0h %0b %0d",
                         $time, "actual code done count", code, done, count);
                return;
            end
            item = expected_codes.pop_front();
            if (code !== item.code) begin
                n_errors++;
                $display("%0t: out_code expected %0h actual %0h", $time, item.code, code);
            end
            if (done !== item.done) begin
                n_errors++;
                $display("%0t: is_done expected %0b actual %0b", $time, item.done, done);
            end
            if (count !== item.count) begin
                n_errors++;
                $display("%0t: code_count expected %0d actual %0d", $time, item.count, count);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_code;
    logic        o_is_done;
    logic [15:0] o_code_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    opcode_scoreboard board;
    int n_bytes_taken;
    int n_cfg_writes;
    int n_cycles;
    int in_idle_pct;
    int out_stall_pct;
    int out_hold;

    utf8_syllable_opcode_parser u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_code   (o_out_code),
        .o_is_done    (o_is_done),
        .o_code_count (o_code_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                board.set_capacity(i_cfg_data);
                n_cfg_writes++;
            end
            if (i_in_valid && o_in_ready) begin
                board.note_byte(i_in_byte);
                n_bytes_taken++;
            end
            if (o_out_valid && i_out_ready)
                board.check_result(o_out_code, o_is_done, o_code_count);
        end
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold > 0) begin
                i_out_ready <= 1'b0;
                out_hold--;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
            end
        end
    end

    initial begin
        n_cycles = 0;
        while (n_cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("utf8_syllable_opcode_parser test failed");
        $finish;
    end

    function automatic logic [7:0] tail_byte();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(1, 255));
        return 8'($urandom_range(128, 191));
    endfunction

    function automatic logic [7:0] stray_byte();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(128, 223));
        return 8'($urandom_range(240, 255));
    endfunction

    task automatic push_byte(input logic [7:0] b);
        int seen;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        seen = n_bytes_taken;
        do @(negedge i_clk); while (n_bytes_taken == seen);
    endtask

    task automatic push_string(input int max_syms);
        int n_syms;
        int kind;
        logic [7:0] lead;
        n_syms = $urandom_range(0, max_syms);
        for (int s = 0; s < n_syms; s++) begin
            kind = $urandom_range(0, 99);
            lead = {4'hE, 4'($urandom_range(0, 15))};
            if (kind < 40) begin
                push_byte(8'($urandom_range(1, 127)));
            end else if (kind < 80) begin
                push_byte(lead);
                push_byte(tail_byte());
                push_byte(tail_byte());
            end else if (kind < 90) begin
                push_byte(stray_byte());
            end else begin
                push_byte(lead);
                if (kind >= 95)
                    push_byte(8'($urandom_range(1, 255)));
            end
        end
        kind = $urandom_range(0, 5);
        lead = {4'hE, 4'($urandom_range(0, 15))};
        if (kind <= 1)
            push_byte(lead);
        if (kind == 1)
            push_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 127))
                                                  : 8'($urandom_range(128, 255)));
        push_byte(NUL_BYTE);
    endtask

    // sender parks, then waits for every result and for the block to settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        int seen;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        seen = n_cfg_writes;
        do @(negedge i_clk); while (n_cfg_writes == seen);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0]  directed[$];
        logic [15:0] caps[8];
        int          start;
        bit          paused;
        board         = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_byte     = 8'd0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 16'd0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        out_hold      = 0;
        n_bytes_taken = 0;
        n_cfg_writes  = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty string, ascii edges, strays, all five opcodes, truncated tails
        directed = '{8'h00, 8'h7F, 8'h01, 8'hFF, 8'h80,
                     8'hE0, 8'h80, 8'h80, 8'hEA, 8'hB0, 8'h81, 8'hEA, 8'hB0, 8'h82,
                     8'hEF, 8'hBF, 8'hBF, 8'hEA, 8'hB0, 8'h84, 8'h00,
                     8'hE5, 8'h00, 8'hE5, 8'h41, 8'h00, 8'hE5, 8'hC1, 8'h00,
                     8'h41, 8'h42};
        foreach (directed[i])
            push_byte(directed[i]);
        // capacity lowered below the count in the middle of a string
        wait_drained();
        write_capacity(16'd1);
        push_byte(8'h43);
        push_byte(NUL_BYTE);

        caps = '{CAPACITY_DEFAULT, 16'd0, 16'd65535, 16'd1,
                 16'($urandom_range(2, 10)), 16'd3, 16'($urandom_range(1, 20)), 16'd65535};
        paused = 1'b0;
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            write_capacity(caps[p]);
            in_idle_pct   = (p % 4 == 1) ? 80 : (p % 4 == 3) ? 8 : 0;
            out_stall_pct = (p % 4 == 2) ? 80 : (p % 4 == 3) ? 8 : 0;
            if (p % 4 == 0)
                out_hold = 80;
            start = n_bytes_taken;
            while (n_bytes_taken - start < PHASE_BYTES) begin
                push_string(12);
                if (p == 5 && !paused && n_bytes_taken - start >= PHASE_BYTES / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        if (board.n_errors == 0)
            $display("utf8_syllable_opcode_parser test passed");
        else
            $display("utf8_syllable_opcode_parser test failed");
        $finish;
    end

endmodule
